### design/websocket_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shorthand for clocked concurrent assertions, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Checked only while the block is out of reset.
`define WSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Parser phases and header field constants shared by the deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_HALT    = 3'd5
  } phase_e;

  localparam logic [3:0]  OpcodeMask   = 4'hF;
  localparam int unsigned MaskBitPos   = 7;
  localparam logic [6:0]  Len7Ext16    = 7'd126;
  localparam logic [6:0]  Len7Ext64    = 7'd127;
  localparam logic [3:0]  Ext16Bytes   = 4'd2;
  localparam logic [3:0]  Ext64Bytes   = 4'd8;
  localparam logic [3:0]  KeyBytes     = 4'd4;
  localparam logic [15:0] MaxPayloadRst = 16'd8192;

  // Register index decoded from paddr[2].
  localparam logic RegMaxPayload = 1'b0;

endpackage

### design/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a client-to-server byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
// One byte is taken per clock with no gaps while results are not held back.
// A byte waits in the input register, where the header/payload logic works on
// it, and its result is written into the output register once that is free.
// The input stalls only while the input register holds a byte and the output
// register holds a result that is itself stalled. Header bytes give no result;
// each payload byte gives one, an empty frame gives one without a byte, and a
// frame longer than max_payload (register at byte address 0) gives one error
// result, after which every byte is consumed and dropped until reset.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // Results out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        has_byte_o,
  output logic [3:0]  opcode_o,
  output logic        last_of_frame_o,
  output logic [15:0] frame_length_o,
  output logic        error_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wsfd_pkg::*;

  // Configuration register.
  logic [15:0] max_payload_q;
  logic        cfg_write;

  // Input register.
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_accept;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [15:0] len_q, len_d;     // low 16 bits of the frame length
  logic        hi_q, hi_d;       // some length bit above bit 15 is set
  logic [3:0]  ext_q, ext_d;
  logic [31:0] key_q, key_d;
  logic [15:0] pidx_q, pidx_d;

  // Result of the current byte.
  logic        out_free;
  logic        proc_go;
  logic        res_valid;
  logic [7:0]  res_byte;
  logic        res_has;
  logic        res_last;
  logic [15:0] res_len;
  logic        res_err;
  logic        chk_len;
  logic        start_pl;
  logic [7:0]  key_byte;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_has_q;
  logic [3:0]  out_opcode_q;
  logic        out_last_q;
  logic [15:0] out_len_q;
  logic        out_err_q;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegMaxPayload);
  assign prdata    = (paddr[2] == RegMaxPayload) ? {16'd0, max_payload_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadRst;
    end else if (cfg_write) begin
      max_payload_q <= pwdata[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_go    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Frame parser
  // --------------------------------------------------------------------------
  // Key byte for this payload position: position 0 uses bits 31..24.
  always_comb begin
    case (pidx_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    len_d     = len_q;
    hi_d      = hi_q;
    ext_d     = ext_q;
    key_d     = key_q;
    pidx_d    = pidx_q;
    res_valid = 1'b0;
    res_byte  = 8'd0;
    res_has   = 1'b0;
    res_last  = 1'b0;
    res_len   = 16'd0;
    res_err   = 1'b0;
    chk_len   = 1'b0;
    start_pl  = 1'b0;

    if (proc_go) begin
      case (phase_q)
        PH_HDR0: begin
          opcode_d = in_byte_q[3:0] & OpcodeMask;
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = in_byte_q[MaskBitPos];
          hi_d   = 1'b0;
          if (in_byte_q[6:0] == Len7Ext16 || in_byte_q[6:0] == Len7Ext64) begin
            ext_d   = (in_byte_q[6:0] == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
            len_d   = 16'd0;
            phase_d = PH_EXT;
          end else begin
            len_d   = {9'd0, in_byte_q[6:0]};
            chk_len = 1'b1;
          end
        end
        PH_EXT: begin
          // Only the low 16 bits are kept; anything shifted past them is
          // folded into the sticky high flag.
          len_d = {len_q[7:0], in_byte_q};
          hi_d  = hi_q || (len_q[15:8] != 8'd0);
          ext_d = ext_q - 4'd1;
          if (ext_d == 4'd0) begin
            chk_len = 1'b1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], in_byte_q};
          ext_d = ext_q - 4'd1;
          if (ext_d == 4'd0) begin
            start_pl = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          pidx_d    = pidx_q + 16'd1;
          res_valid = 1'b1;
          res_byte  = in_byte_q ^ key_byte;
          res_has   = 1'b1;
          res_len   = len_q;
          res_last  = (pidx_d >= len_q);
          if (res_last) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          // Halted, and any unused code: the byte is dropped.
        end
      endcase

      // The length is complete: check it against the limit before the key.
      if (chk_len) begin
        if (hi_d || (len_d > max_payload_q)) begin
          phase_d   = PH_HALT;
          res_valid = 1'b1;
          res_last  = 1'b1;
          res_err   = 1'b1;
          res_len   = hi_d ? 16'hFFFF : len_d;
        end else begin
          key_d = 32'd0;
          if (mask_d) begin
            ext_d   = KeyBytes;
            phase_d = PH_KEY;
          end else begin
            start_pl = 1'b1;
          end
        end
      end

      // The header is complete: an empty frame ends here with one result.
      if (start_pl) begin
        if (!hi_d && (len_d == 16'd0)) begin
          phase_d   = PH_HDR0;
          res_valid = 1'b1;
          res_last  = 1'b1;
        end else begin
          pidx_d  = 16'd0;
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= 4'd0;
      mask_q   <= 1'b0;
      len_q    <= 16'd0;
      hi_q     <= 1'b0;
      ext_q    <= 4'd0;
      key_q    <= 32'd0;
      pidx_q   <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      hi_q     <= hi_d;
      ext_q    <= ext_d;
      key_q    <= key_d;
      pidx_q   <= pidx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc_go && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && res_valid) begin
      out_byte_q   <= res_byte;
      out_has_q    <= res_has;
      out_opcode_q <= opcode_q;
      out_last_q   <= res_last;
      out_len_q    <= res_len;
      out_err_q    <= res_err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign has_byte_o      = out_has_q;
  assign opcode_o        = out_opcode_q;
  assign last_of_frame_o = out_last_q;
  assign frame_length_o  = out_len_q;
  assign error_o         = out_err_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `include "websocket_frame_deframer_assert.svh"

  `WSFD_ASSERT(a_halt_sticky, (phase_q == PH_HALT) |=> (phase_q == PH_HALT),
    "deframer left the halted state")
  `WSFD_ASSERT(a_err_shape, (out_valid_q && out_err_q) |->
    (out_last_q && !out_has_q && (phase_q == PH_HALT)), "error result without halt")
  `WSFD_ASSERT(a_empty_byte, (out_valid_q && !out_has_q) |->
    (out_byte_q == 8'd0 && out_last_q), "result without byte is malformed")
  `WSFD_ASSERT_ALWAYS(a_stall_cause, in_stall_o |->
    (in_valid_q && out_valid_q && out_stall_i), "input stalled while the output register is free")

endmodule
